>>> sv/lfe_pkg.sv
// shared types and codes for the frame link engine
// no dependencies; imported by every module of the engine
`default_nettype none

package lfe_pkg;

    // default depth of the event queue between front and back
    localparam int LFE_QUEUE_DEPTH = 4;

    // event codes of the input operation field
    typedef enum logic [1:0] {
        OP_SYNC = 2'd0,
        OP_RX   = 2'd1,
        OP_SENT = 2'd2,
        OP_REQ  = 2'd3
    } op_t;

    // transmit action codes
    localparam logic [1:0] TX_NONE = 2'd0;
    localparam logic [1:0] TX_SYNC = 2'd1;
    localparam logic [1:0] TX_BYTE = 2'd2;

    // header byte positions
    localparam logic [15:0] HDR_TYPE  = 16'd1;
    localparam logic [15:0] HDR_LEN_H = 16'd2;
    localparam logic [15:0] HDR_LEN_L = 16'd3;
    localparam logic [15:0] HDR_DEST  = 16'd4;
    localparam logic [15:0] HDR_SRC   = 16'd5;

    // engine phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_RXHDR = 5'b00010,
        PH_RXPAY = 5'b00100,
        PH_TXHDR = 5'b01000,
        PH_TXPAY = 5'b10000
    } phase_t;

    // classified event handed from front to back
    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic [7:0]  req_type;
        logic [15:0] req_length;
        logic [7:0]  req_dest;
        logic [7:0]  req_src;
    } event_t;

    // one result transaction
    typedef struct packed {
        logic        accepted;
        logic [1:0]  tx_kind;
        logic [7:0]  tx_byte;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        frame_done_rx;
        logic        frame_done_tx;
        logic [7:0]  rx_type;
        logic [15:0] rx_length;
        logic [7:0]  rx_dest;
        logic [7:0]  rx_src;
    } result_t;

endpackage

`default_nettype wire

>>> sv/lfe_front.sv
// front stage: accepts input transactions and classifies them into events
// depends on lfe_pkg
`default_nettype none

module lfe_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [1:0]     s_operation,
    input  wire logic [7:0]     s_rx_byte,
    input  wire logic [7:0]     s_tx_payload_byte,
    input  wire logic [7:0]     s_req_type,
    input  wire logic [15:0]    s_req_length,
    input  wire logic [7:0]     s_req_dest,
    input  wire logic [7:0]     s_req_src,
    output logic                ev_valid,
    input  wire logic           ev_ready,
    output lfe_pkg::event_t     ev_data
);
    import lfe_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    event_t ev_reg;
    event_t ev_next;

    // stage frees up when empty or its event moves on
    assign s_ready  = !valid_reg || ev_ready;
    assign ev_valid = valid_reg;
    assign ev_data  = ev_reg;

    // classify: keep only the byte the operation uses
    always_comb begin
        ev_next.op         = op_t'(s_operation);
        ev_next.data       = (op_t'(s_operation) == OP_RX) ? s_rx_byte : s_tx_payload_byte;
        ev_next.req_type   = s_req_type;
        ev_next.req_length = s_req_length;
        ev_next.req_dest   = s_req_dest;
        ev_next.req_src    = s_req_src;
    end

    always_comb begin
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (ev_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // event payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ev_reg <= ev_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/lfe_queue.sv
// small event queue between front and back stages
// depends on lfe_pkg
`default_nettype none

module lfe_queue #(
    parameter int DEPTH = lfe_pkg::LFE_QUEUE_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire lfe_pkg::event_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output lfe_pkg::event_t     out_data
);
    import lfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    event_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != FULL);
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer wrap and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot write
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/lfe_back.sv
// back stage: frame state machine and registered result output
// depends on lfe_pkg
`default_nettype none

module lfe_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            ev_valid,
    output logic                 ev_ready,
    input  wire lfe_pkg::event_t ev_data,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output lfe_pkg::result_t     res_data
);
    import lfe_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] index_reg, index_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  dest_reg, dest_next;
    logic [7:0]  src_reg, src_next;
    logic        valid_reg, valid_next;
    result_t     res_reg, res_next;
    logic [15:0] index_inc;
    logic        pay_last;
    logic        pop;

    assign pop       = ev_valid && (!valid_reg || res_ready);
    assign ev_ready  = !valid_reg || res_ready;
    assign res_valid = valid_reg;
    assign res_data  = res_reg;
    assign index_inc = index_reg + 16'd1;
    // payload ends at the header length, or on index wrap
    assign pay_last  = (index_inc >= len_reg) || (index_inc == 16'd0);

    // next state and result of one event
    always_comb begin
        phase_next = phase_reg;
        index_next = index_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        dest_next  = dest_reg;
        src_next   = src_reg;
        res_next   = '0;
        case (ev_data.op)
            OP_SYNC: begin
                if (phase_reg == PH_IDLE) begin
                    phase_next = PH_RXHDR;
                    index_next = HDR_TYPE;
                end
            end
            OP_RX: begin
                if (phase_reg == PH_RXHDR) begin
                    case (index_reg)
                        HDR_TYPE: begin
                            type_next  = ev_data.data;
                            index_next = HDR_LEN_H;
                        end
                        HDR_LEN_H: begin
                            len_next   = {ev_data.data, 8'd0};
                            index_next = HDR_LEN_L;
                        end
                        HDR_LEN_L: begin
                            len_next   = {len_reg[15:8], ev_data.data};
                            index_next = HDR_DEST;
                        end
                        HDR_DEST: begin
                            dest_next  = ev_data.data;
                            index_next = HDR_SRC;
                        end
                        HDR_SRC: begin
                            src_next   = ev_data.data;
                            index_next = 16'd0;
                            if (len_reg == 16'd0) begin
                                phase_next             = PH_IDLE;
                                res_next.frame_done_rx = 1'b1;
                            end else begin
                                phase_next = PH_RXPAY;
                            end
                        end
                        default: begin
                            index_next = index_inc;
                        end
                    endcase
                end else if (phase_reg == PH_RXPAY) begin
                    res_next.payload_valid = 1'b1;
                    res_next.payload_byte  = ev_data.data;
                    res_next.payload_index = index_reg;
                    index_next             = index_inc;
                    if (pay_last) begin
                        phase_next             = PH_IDLE;
                        res_next.frame_done_rx = 1'b1;
                    end
                end
            end
            OP_SENT: begin
                if (phase_reg == PH_TXHDR) begin
                    res_next.tx_kind = TX_BYTE;
                    case (index_reg)
                        HDR_TYPE: begin
                            res_next.tx_byte = type_reg;
                            index_next       = HDR_LEN_H;
                        end
                        HDR_LEN_H: begin
                            res_next.tx_byte = len_reg[15:8];
                            index_next       = HDR_LEN_L;
                        end
                        HDR_LEN_L: begin
                            res_next.tx_byte = len_reg[7:0];
                            index_next       = HDR_DEST;
                        end
                        HDR_DEST: begin
                            res_next.tx_byte = dest_reg;
                            index_next       = HDR_SRC;
                        end
                        HDR_SRC: begin
                            res_next.tx_byte = src_reg;
                            index_next       = 16'd0;
                            if (len_reg == 16'd0) begin
                                phase_next             = PH_IDLE;
                                res_next.frame_done_tx = 1'b1;
                            end else begin
                                phase_next = PH_TXPAY;
                            end
                        end
                        default: begin
                            // lost header position: resend sync, restart at type
                            res_next.tx_kind = TX_SYNC;
                            index_next       = HDR_TYPE;
                        end
                    endcase
                end else if (phase_reg == PH_TXPAY) begin
                    res_next.tx_kind = TX_BYTE;
                    res_next.tx_byte = ev_data.data;
                    index_next       = index_inc;
                    if (pay_last) begin
                        phase_next             = PH_IDLE;
                        res_next.frame_done_tx = 1'b1;
                    end
                end
                // tell the caller which payload byte is wanted next
                if (phase_next == PH_TXPAY) begin
                    res_next.payload_index = index_next;
                end
            end
            OP_REQ: begin
                if (phase_reg == PH_IDLE) begin
                    type_next         = ev_data.req_type;
                    len_next          = ev_data.req_length;
                    dest_next         = ev_data.req_dest;
                    src_next          = ev_data.req_src;
                    index_next        = HDR_TYPE;
                    phase_next        = PH_TXHDR;
                    res_next.accepted = 1'b1;
                    res_next.tx_kind  = TX_SYNC;
                end
            end
            default: begin
            end
        endcase
        res_next.rx_type   = type_next;
        res_next.rx_length = len_next;
        res_next.rx_dest   = dest_next;
        res_next.rx_src    = src_next;
    end

    // output register handshake
    always_comb begin
        if (pop) begin
            valid_next = 1'b1;
        end else if (res_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            index_reg <= '0;
            type_reg  <= '0;
            len_reg   <= '0;
            dest_reg  <= '0;
            src_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (pop) begin
                phase_reg <= phase_next;
                index_reg <= index_next;
                type_reg  <= type_next;
                len_reg   <= len_next;
                dest_reg  <= dest_next;
                src_reg   <= src_next;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge aclk) begin
        if (pop) begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/link_frame_rx_tx_engine.sv
// half-duplex frame link engine, top level; uses lfe_pkg, lfe_front, lfe_queue, lfe_back
// path: each transaction passes the front register, the event queue and the back-stage result register
// throughput: one transaction per cycle while m_ready stays high, set by the state update in the back
// stage; the event queue absorbs up to QUEUE_DEPTH events while the result side stalls
// reset: synchronous active-low aresetn returns to idle with header registers cleared
// and all stages empty
`default_nettype none

module link_frame_rx_tx_engine #(
    parameter int QUEUE_DEPTH = lfe_pkg::LFE_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic [7:0]  s_tx_payload_byte,
    input  wire logic [7:0]  s_req_type,
    input  wire logic [15:0] s_req_length,
    input  wire logic [7:0]  s_req_dest,
    input  wire logic [7:0]  s_req_src,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_accepted,
    output logic [1:0]       m_tx_kind,
    output logic [7:0]       m_tx_byte,
    output logic             m_payload_valid,
    output logic [7:0]       m_payload_byte,
    output logic [15:0]      m_payload_index,
    output logic             m_frame_done_rx,
    output logic             m_frame_done_tx,
    output logic [7:0]       m_rx_type,
    output logic [15:0]      m_rx_length,
    output logic [7:0]       m_rx_dest,
    output logic [7:0]       m_rx_src
);
    import lfe_pkg::*;

    logic    fe_valid, fe_ready;
    event_t  fe_data;
    logic    q_valid, q_ready;
    event_t  q_data;
    result_t res;

    lfe_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_rx_byte         (s_rx_byte),
        .s_tx_payload_byte (s_tx_payload_byte),
        .s_req_type        (s_req_type),
        .s_req_length      (s_req_length),
        .s_req_dest        (s_req_dest),
        .s_req_src         (s_req_src),
        .ev_valid          (fe_valid),
        .ev_ready          (fe_ready),
        .ev_data           (fe_data)
    );

    lfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_data   (fe_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    lfe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ev_valid  (q_valid),
        .ev_ready  (q_ready),
        .ev_data   (q_data),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res_data  (res)
    );

    // break the result out onto ports
    assign m_accepted      = res.accepted;
    assign m_tx_kind       = res.tx_kind;
    assign m_tx_byte       = res.tx_byte;
    assign m_payload_valid = res.payload_valid;
    assign m_payload_byte  = res.payload_byte;
    assign m_payload_index = res.payload_index;
    assign m_frame_done_rx = res.frame_done_rx;
    assign m_frame_done_tx = res.frame_done_tx;
    assign m_rx_type       = res.rx_type;
    assign m_rx_length     = res.rx_length;
    assign m_rx_dest       = res.rx_dest;
    assign m_rx_src        = res.rx_src;

    // an accepted send request always starts with a sync
    a_accept_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> m_tx_kind == TX_SYNC)
        else $error("accepted request without sync");

    // half duplex: never both directions finishing in one transaction
    a_one_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_frame_done_rx && m_frame_done_tx))
        else $error("rx and tx done together");

    // a received payload byte carries no transmit action
    a_rx_no_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload_valid |-> m_tx_kind == TX_NONE)
        else $error("transmit action on receive");

    // last received payload byte sits at the end of the header length
    a_rx_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload_valid && m_frame_done_rx |->
            ({1'b0, m_payload_index} + 17'd1) >= {1'b0, m_rx_length})
        else $error("receive frame ended early");

endmodule

`default_nettype wire

>>> test/link_frame_rx_tx_engine_tb.sv
// self-checking testbench for the half-duplex frame link engine
// depends on lfe_pkg and link_frame_rx_tx_engine; a directed table, then random frames
`timescale 1ns / 100ps

module link_frame_rx_tx_engine_tb;
    import lfe_pkg::*;

    // one event as driven on the input channel
    typedef struct packed {
        op_t         op;
        logic [7:0]  rx_byte;
        logic [7:0]  tx_payload;
        logic [7:0]  req_type;
        logic [15:0] req_length;
        logic [7:0]  req_dest;
        logic [7:0]  req_src;
    } link_ev_t;

    // directed stimulus row, with an optional hand-written expectation
    typedef struct {
        link_ev_t ev;
        bit       typed;
        result_t  want;
    } dir_row_t;

    localparam int TOTAL_EVENTS = 1050;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [7:0]  s_rx_byte;
    logic [7:0]  s_tx_payload_byte;
    logic [7:0]  s_req_type;
    logic [15:0] s_req_length;
    logic [7:0]  s_req_dest;
    logic [7:0]  s_req_src;
    logic        m_valid;
    logic        m_ready;
    logic        m_accepted;
    logic [1:0]  m_tx_kind;
    logic [7:0]  m_tx_byte;
    logic        m_payload_valid;
    logic [7:0]  m_payload_byte;
    logic [15:0] m_payload_index;
    logic        m_frame_done_rx;
    logic        m_frame_done_tx;
    logic [7:0]  m_rx_type;
    logic [15:0] m_rx_length;
    logic [7:0]  m_rx_dest;
    logic [7:0]  m_rx_src;

    // engine state as the predictor sees it
    phase_t      eng_phase;
    logic [15:0] eng_index;
    logic [7:0]  eng_type;
    logic [15:0] eng_length;
    logic [7:0]  eng_dest;
    logic [7:0]  eng_src;
    logic [15:0] rx_len_plan;

    result_t     pending_results[$];
    dir_row_t    dir_tab[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned events_sent;
    int unsigned rx_frames;
    int unsigned tx_frames;
    int unsigned rx_payload_bytes;
    int unsigned ready_hold;
    bit          steady;

    link_frame_rx_tx_engine u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_rx_byte         (s_rx_byte),
        .s_tx_payload_byte (s_tx_payload_byte),
        .s_req_type        (s_req_type),
        .s_req_length      (s_req_length),
        .s_req_dest        (s_req_dest),
        .s_req_src         (s_req_src),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_accepted        (m_accepted),
        .m_tx_kind         (m_tx_kind),
        .m_tx_byte         (m_tx_byte),
        .m_payload_valid   (m_payload_valid),
        .m_payload_byte    (m_payload_byte),
        .m_payload_index   (m_payload_index),
        .m_frame_done_rx   (m_frame_done_rx),
        .m_frame_done_tx   (m_frame_done_tx),
        .m_rx_type         (m_rx_type),
        .m_rx_length       (m_rx_length),
        .m_rx_dest         (m_rx_dest),
        .m_rx_src          (m_rx_src)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // one mismatch line, printing capped
    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("%0t ns mismatch: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d field %s: got %0h, want %0h",
                                      results_seen, name, got, want));
        end
    endtask

    // predicts the result of one accepted event and advances the engine state
    function automatic result_t advance_engine(input link_ev_t ev);
        result_t r;
        r = '0;
        case (ev.op)
            OP_SYNC: begin
                if (eng_phase == PH_IDLE) begin
                    eng_phase = PH_RXHDR;
                    eng_index = HDR_TYPE;
                end
            end
            OP_RX: begin
                if (eng_phase == PH_RXHDR) begin
                    case (eng_index)
                        HDR_TYPE:  eng_type = ev.rx_byte;
                        HDR_LEN_H: eng_length = {ev.rx_byte, 8'h00};
                        HDR_LEN_L: eng_length[7:0] = ev.rx_byte;
                        HDR_DEST:  eng_dest = ev.rx_byte;
                        HDR_SRC:   eng_src = ev.rx_byte;
                        default: ;
                    endcase
                    if (eng_index == HDR_SRC) begin
                        eng_index = '0;
                        if (eng_length == '0) begin
                            eng_phase = PH_IDLE;
                            r.frame_done_rx = 1'b1;
                        end else begin
                            eng_phase = PH_RXPAY;
                        end
                    end else begin
                        // an out-of-range index drops the byte and still advances
                        eng_index = eng_index + 16'd1;
                    end
                end else if (eng_phase == PH_RXPAY) begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = ev.rx_byte;
                    r.payload_index = eng_index;
                    eng_index = eng_index + 16'd1;
                    if (eng_index >= eng_length || eng_index == '0) begin
                        eng_phase = PH_IDLE;
                        r.frame_done_rx = 1'b1;
                    end
                end
            end
            OP_SENT: begin
                if (eng_phase == PH_TXHDR) begin
                    r.tx_kind = TX_BYTE;
                    case (eng_index)
                        HDR_TYPE:  r.tx_byte = eng_type;
                        HDR_LEN_H: r.tx_byte = eng_length[15:8];
                        HDR_LEN_L: r.tx_byte = eng_length[7:0];
                        HDR_DEST:  r.tx_byte = eng_dest;
                        HDR_SRC:   r.tx_byte = eng_src;
                        default:   r.tx_kind = TX_SYNC;
                    endcase
                    if (eng_index == HDR_SRC) begin
                        eng_index = '0;
                        if (eng_length == '0) begin
                            eng_phase = PH_IDLE;
                            r.frame_done_tx = 1'b1;
                        end else begin
                            eng_phase = PH_TXPAY;
                        end
                    end else if (eng_index >= HDR_TYPE && eng_index < HDR_SRC) begin
                        eng_index = eng_index + 16'd1;
                    end else begin
                        // bad header index: resend the sync and restart the header
                        eng_index = HDR_TYPE;
                    end
                end else if (eng_phase == PH_TXPAY) begin
                    r.tx_kind = TX_BYTE;
                    r.tx_byte = ev.tx_payload;
                    eng_index = eng_index + 16'd1;
                    if (eng_index >= eng_length || eng_index == '0) begin
                        eng_phase = PH_IDLE;
                        r.frame_done_tx = 1'b1;
                    end
                end
                if (eng_phase == PH_TXPAY) begin
                    r.payload_index = eng_index;
                end
            end
            default: begin
                if (eng_phase == PH_IDLE) begin
                    eng_type   = ev.req_type;
                    eng_length = ev.req_length;
                    eng_dest   = ev.req_dest;
                    eng_src    = ev.req_src;
                    eng_index  = HDR_TYPE;
                    eng_phase  = PH_TXHDR;
                    r.accepted = 1'b1;
                    r.tx_kind  = TX_SYNC;
                end
            end
        endcase
        r.rx_type   = eng_type;
        r.rx_length = eng_length;
        r.rx_dest   = eng_dest;
        r.rx_src    = eng_src;
        return r;
    endfunction

    function automatic dir_row_t dir(input op_t op, input logic [7:0] data,
                                     input logic [7:0] rt, input logic [15:0] rl,
                                     input logic [7:0] rd, input logic [7:0] rs,
                                     input bit typed, input result_t want);
        dir_row_t row;
        row.ev.op         = op;
        row.ev.rx_byte    = data;
        row.ev.tx_payload = data;
        row.ev.req_type   = rt;
        row.ev.req_length = rl;
        row.ev.req_dest   = rd;
        row.ev.req_src    = rs;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    // idle stretch: mostly short, now and then long
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 99) < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // frame lengths: mostly short, a few long ones
    function automatic logic [15:0] frame_length();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 65) begin
            return 16'($urandom_range(0, 6));
        end else if (p < 90) begin
            return 16'($urandom_range(7, 40));
        end else if (p < 98) begin
            return 16'($urandom_range(41, 255));
        end
        return 16'($urandom_range(256, 400));
    endfunction

    // next event: well-formed for the current phase, with some out-of-place noise
    function automatic void next_event(output link_ev_t ev, output bit noise);
        ev.rx_byte    = 8'($urandom);
        ev.tx_payload = 8'($urandom);
        ev.req_type   = 8'($urandom);
        ev.req_length = 16'($urandom);
        ev.req_dest   = 8'($urandom);
        ev.req_src    = 8'($urandom);
        noise = ($urandom_range(0, 99) < 10);
        case (eng_phase)
            PH_IDLE: begin
                if (noise) begin
                    ev.op = ($urandom_range(0, 1) != 0) ? OP_RX : OP_SENT;
                end else if ($urandom_range(0, 1) != 0) begin
                    ev.op = OP_SYNC;
                end else begin
                    ev.op = OP_REQ;
                    ev.req_length = frame_length();
                end
            end
            PH_RXHDR, PH_RXPAY: begin
                if (noise) begin
                    case ($urandom_range(0, 2))
                        0:       ev.op = OP_SYNC;
                        1:       ev.op = OP_SENT;
                        default: ev.op = OP_REQ;
                    endcase
                end else begin
                    ev.op = OP_RX;
                    if (eng_phase == PH_RXHDR && eng_index == HDR_LEN_H) begin
                        rx_len_plan = frame_length();
                        ev.rx_byte = rx_len_plan[15:8];
                    end else if (eng_phase == PH_RXHDR && eng_index == HDR_LEN_L) begin
                        ev.rx_byte = rx_len_plan[7:0];
                    end
                end
            end
            default: begin
                if (noise) begin
                    case ($urandom_range(0, 2))
                        0:       ev.op = OP_SYNC;
                        1:       ev.op = OP_RX;
                        default: ev.op = OP_REQ;
                    endcase
                end else begin
                    ev.op = OP_SENT;
                end
            end
        endcase
    endfunction

    // drive one event at the falling edge and wait for its transaction
    task automatic drive_event(input link_ev_t ev, input bit typed, input result_t want);
        int unsigned gap;
        result_t     predicted;
        gap = (steady || $urandom_range(0, 99) < 65) ? 0 : idle_len();
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_operation       <= ev.op;
        s_rx_byte         <= ev.rx_byte;
        s_tx_payload_byte <= ev.tx_payload;
        s_req_type        <= ev.req_type;
        s_req_length      <= ev.req_length;
        s_req_dest        <= ev.req_dest;
        s_req_src         <= ev.req_src;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = advance_engine(ev);
        pending_results.push_back(typed ? want : predicted);
        events_sent++;
    endtask

    // result side back-pressure
    always @(negedge aclk) begin
        if (ready_hold != 0) begin
            m_ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (!steady && $urandom_range(0, 99) < 25) begin
            m_ready <= 1'b0;
            ready_hold <= idle_len() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_seen));
            end else begin
                want = pending_results.pop_front();
                check_field("accepted", m_accepted, want.accepted);
                check_field("tx_kind", m_tx_kind, want.tx_kind);
                check_field("tx_byte", m_tx_byte, want.tx_byte);
                check_field("payload_valid", m_payload_valid, want.payload_valid);
                check_field("payload_byte", m_payload_byte, want.payload_byte);
                check_field("payload_index", m_payload_index, want.payload_index);
                check_field("frame_done_rx", m_frame_done_rx, want.frame_done_rx);
                check_field("frame_done_tx", m_frame_done_tx, want.frame_done_tx);
                check_field("rx_type", m_rx_type, want.rx_type);
                check_field("rx_length", m_rx_length, want.rx_length);
                check_field("rx_dest", m_rx_dest, want.rx_dest);
                check_field("rx_src", m_rx_src, want.rx_src);
                rx_frames        += want.frame_done_rx;
                tx_frames        += want.frame_done_tx;
                rx_payload_bytes += want.payload_valid;
            end
            results_seen++;
        end
    end

    // main sequence
    initial begin : stimulus
        link_ev_t    ev;
        bit          noise;
        int unsigned stray_events;
        int unsigned drain;
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_operation       = OP_SYNC;
        s_rx_byte         = '0;
        s_tx_payload_byte = '0;
        s_req_type        = '0;
        s_req_length      = '0;
        s_req_dest        = '0;
        s_req_src         = '0;
        m_ready           = 1'b0;
        ready_hold        = 0;
        steady            = 1'b0;
        mismatches        = 0;
        results_seen      = 0;
        events_sent       = 0;
        rx_frames         = 0;
        tx_frames         = 0;
        rx_payload_bytes  = 0;
        eng_phase         = PH_IDLE;
        eng_index         = '0;
        eng_type          = '0;
        eng_length        = '0;
        eng_dest          = '0;
        eng_src           = '0;
        rx_len_plan       = '0;

        // directed table: stray events at idle, zero-length send with stray events
        // and a refused request, receive with payload, zero-length receive
        dir_tab.push_back(dir(OP_RX,   8'hFF, 8'h00, 16'h0000, 8'h00, 8'h00, 1, '0));
        dir_tab.push_back(dir(OP_SENT, 8'hFF, 8'h00, 16'h0000, 8'h00, 8'h00, 1, '0));
        dir_tab.push_back(dir(OP_REQ,  8'h00, 8'hFF, 16'h0000, 8'hFF, 8'hFF, 1,
            {1'b1, TX_SYNC, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0,
             8'hFF, 16'h0000, 8'hFF, 8'hFF}));
        dir_tab.push_back(dir(OP_SYNC, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 0, '0));
        dir_tab.push_back(dir(OP_REQ,  8'h00, 8'h00, 16'hFFFF, 8'h00, 8'h00, 1,
            {1'b0, TX_NONE, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b0, 1'b0,
             8'hFF, 16'h0000, 8'hFF, 8'hFF}));
        repeat (5) dir_tab.push_back(dir(OP_SENT, 8'h5A, 8'h00, 16'h0000, 8'h00, 8'h00,
                                         0, '0));
        dir_tab.push_back(dir(OP_SYNC, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 0, '0));
        dir_tab.push_back(dir(OP_RX,   8'hA5, 8'h00, 16'h0000, 8'h00, 8'h00, 0, '0));
        dir_tab.push_back(dir(OP_RX,   8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 0, '0));
        dir_tab.push_back(dir(OP_RX,   8'h02, 8'h00, 16'h0000, 8'h00, 8'h00, 0, '0));
        dir_tab.push_back(dir(OP_RX,   8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 0, '0));
        dir_tab.push_back(dir(OP_RX,   8'hFF, 8'h00, 16'h0000, 8'h00, 8'h00, 0, '0));
        dir_tab.push_back(dir(OP_RX,   8'hFF, 8'h00, 16'h0000, 8'h00, 8'h00, 0, '0));
        dir_tab.push_back(dir(OP_RX,   8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 0, '0));
        dir_tab.push_back(dir(OP_SYNC, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 0, '0));
        dir_tab.push_back(dir(OP_RX,   8'h3C, 8'h00, 16'h0000, 8'h00, 8'h00, 0, '0));
        dir_tab.push_back(dir(OP_RX,   8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 0, '0));
        dir_tab.push_back(dir(OP_RX,   8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 0, '0));
        dir_tab.push_back(dir(OP_RX,   8'hFF, 8'h00, 16'h0000, 8'h00, 8'h00, 0, '0));
        dir_tab.push_back(dir(OP_RX,   8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 1,
            {1'b0, TX_NONE, 8'h00, 1'b0, 8'h00, 16'h0000, 1'b1, 1'b0,
             8'h3C, 16'h0000, 8'hFF, 8'h00}));

        // hold reset, then release it at a falling edge
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            drive_event(dir_tab[i].ev, dir_tab[i].typed, dir_tab[i].want);
        end

        // random frames with some out-of-place events, up to the total event count
        stray_events = 0;
        while (events_sent < TOTAL_EVENTS) begin
            next_event(ev, noise);
            drive_event(ev, 1'b0, '0);
            if (noise) begin
                stray_events++;
            end
            if ($urandom_range(0, 99) == 0) begin
                steady = !steady;
            end
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // drain, then watch a little longer for stray results
        drain = 0;
        while (pending_results.size() != 0 && drain < 20000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (20) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end

        $display("sent %0d transactions (%0d directed, %0d out of place), checked %0d results",
                 events_sent, dir_tab.size(), stray_events, results_seen);
        $display("frames completed: %0d received (%0d payload bytes), %0d sent; %0d mismatches",
                 rx_frames, rx_payload_bytes, tx_frames, mismatches);
        if (mismatches == 0) begin
            $display("link_frame_rx_tx_engine_tb: PASS");
        end else begin
            $display("link_frame_rx_tx_engine_tb: FAIL");
        end
        $finish;
    end

    // run limit: a timeout far beyond the time that about 1050 transactions need
    initial begin : run_limit
        #10_000_000;
        $display("timeout after %0t ns", $time);
        $display("link_frame_rx_tx_engine_tb: FAIL");
        $finish;
    end

endmodule

>>> link_frame_rx_tx_engine.f
sv/lfe_pkg.sv
sv/lfe_front.sv
sv/lfe_queue.sv
sv/lfe_back.sv
sv/link_frame_rx_tx_engine.sv
test/link_frame_rx_tx_engine_tb.sv
